FILE: rtl/gspid_pkg.sv
// Shared types, widths and constants of the gain-scheduled PID controller.
package gspid_pkg;

  // Output limits in whole drive units (Q8.8 value is this times 256).
  localparam int OUT_MAX = 100;
  localparam int OUT_MIN = 0;
  localparam int MS_PER_S = 1000;

  localparam int TEMP_W = 16;
  localparam int ERR_W = TEMP_W + 1;
  localparam int BAND_W = 15;
  localparam int GAIN_W = 16;
  localparam int MS_W = 16;
  localparam int DRIVE_W = 16;
  localparam int ACC_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FUNC_W = 2;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Radix-4 divider: dividend bits, divisor bits, step counter.
  localparam int DIV_N_W = 56;
  localparam int DIV_D_W = 16;
  localparam int DIV_STEP_W = 5;
  // Steps (two quotient bits each) for the three divisions.
  localparam int INC_STEPS = MUL_P_W / 2;
  localparam int LIM_STEPS = 16;
  localparam int DRV_STEPS = DIV_N_W / 2;
  localparam int LIM_NUM = OUT_MAX * (2 ** 24);

  // Output sum and rounding.
  localparam int SUM_W = 60;
  localparam int FRAC_SHIFT = 16;
  localparam int RND_W = SUM_W - FRAC_SHIFT;
  localparam logic signed [RND_W:0] DRIVE_HI = (RND_W + 1)'(OUT_MAX * 256);
  localparam logic signed [RND_W:0] DRIVE_LO = (RND_W + 1)'(OUT_MIN * 256);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] TARGET_RST = 16'sd3200;
  localparam logic [BAND_W-1:0] BAND_RST = 15'd160;
  localparam logic [GAIN_W-1:0] KP_G_RST = 16'd512;
  localparam logic [GAIN_W-1:0] KI_G_RST = 16'd13;
  localparam logic [GAIN_W-1:0] KD_G_RST = 16'd64;
  localparam logic [GAIN_W-1:0] KP_S_RST = 16'd1024;
  localparam logic [GAIN_W-1:0] KI_S_RST = 16'd51;
  localparam logic [GAIN_W-1:0] KD_S_RST = 16'd256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE,
    FUNC_ENABLE,
    FUNC_DISABLE,
    FUNC_RESET
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET,
    REG_BAND,
    REG_KP_GENTLE,
    REG_KI_GENTLE,
    REG_KD_GENTLE,
    REG_KP_STRONG,
    REG_KI_STRONG,
    REG_KD_STRONG
  } cfg_reg_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_N_W-1:0]    dividend;
    logic [DIV_D_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/gspid_mul.sv
// Shared signed multiplier with a registered product.
module gspid_mul (
  input  logic                                   clk,
  input  logic signed [gspid_pkg::MUL_A_W-1:0]   a,
  input  logic signed [gspid_pkg::MUL_B_W-1:0]   b,
  output logic signed [gspid_pkg::MUL_P_W-1:0]   p
);
  import gspid_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: rtl/gspid_div.sv
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module gspid_div (
  input  logic                 clk,
  input  logic                 rst,
  input  gspid_pkg::div_req_t  req,
  output gspid_pkg::div_rsp_t  rsp
);
  import gspid_pkg::*;

  logic [DIV_N_W-1:0]    work;
  logic [DIV_D_W-1:0]    rem;
  logic [DIV_D_W-1:0]    dsor;
  logic [DIV_STEP_W-1:0] left;
  logic                  busy;

  logic [DIV_D_W:0] t1, r1, t2, r2;
  logic             q1, q2;

  // Two dividend bits enter the remainder, one compare-subtract per bit.
  always_comb begin
    t1 = {rem, work[DIV_N_W-1]};
    q1 = t1 >= {1'b0, dsor};
    r1 = q1 ? t1 - {1'b0, dsor} : t1;
    t2 = {r1[DIV_D_W-1:0], work[DIV_N_W-2]};
    q2 = t2 >= {1'b0, dsor};
    r2 = q2 ? t2 - {1'b0, dsor} : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dsor <= req.divisor;
      left <= req.steps;
      busy <= req.steps != '0;
    end else if (busy) begin
      work <= {work[DIV_N_W-3:0], q1, q2};
      rem  <= r2[DIV_D_W-1:0];
      left <= left - 1'b1;
      if (left == DIV_STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = work;

endmodule

FILE: rtl/gain_scheduled_pid_controller.sv
// Top level of the gain-scheduled PID temperature controller.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tuser: func; s_tdata: sample_temp, elapsed_ms
//   m_*      out  m_tvalid/m_tready   m_tdata: drive_level, running, strong_gains
//   cfg_*    in   cfg_valid/cfg_ready cfg_index: register, cfg_data: value
//
// Enable, disable, reset, and samples that only prime or change nothing
// go from accept straight to the done state, which presents the result.
// A full sample runs the three divisions on the shared radix-4 divider
// (23, 16 and 28 steps); with ki zero the 16-step limit division and its
// wait state are skipped.
// Reset is synchronous and restores register defaults and clears state.
// A finished result waits in the output register; the next item is taken
// while it waits, and a full sample holds in its last state until the
// output register is free.
module gain_scheduled_pid_controller (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sample_temp, [31:16] elapsed_ms
  input  logic [1:0]  s_tuser,   // [1:0] func
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] drive_level, [16] running, [17] strong_gains
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gspid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL,
    S_GAIN,
    S_INC,
    S_P,
    S_DT,
    S_D,
    S_WINC,
    S_WLIM,
    S_I0,
    S_I1,
    S_I2,
    S_WD,
    S_RND,
    S_CLIP,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [TEMP_W-1:0] target_temp;
  logic [BAND_W-1:0]        switch_band;
  logic [GAIN_W-1:0]        kp_gentle, ki_gentle, kd_gentle;
  logic [GAIN_W-1:0]        kp_strong, ki_strong, kd_strong;

  // Controller state.
  logic                      enabled_flag, primed_flag, strong_mode;
  logic signed [ACC_W-1:0]   integral_acc;
  logic signed [TEMP_W-1:0]  prev_temp;
  logic signed [DRIVE_W-1:0] drive_reg;

  // Working registers of one sample.
  logic signed [TEMP_W-1:0]  samp_temp;
  logic [MS_W-1:0]           samp_ms;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   dtemp;
  logic [GAIN_W-1:0]         kp, ki, kd;
  logic                      inc_neg, d_neg, rnd_neg;
  logic [DIV_N_W-1:0]        d_dividend;
  logic signed [SUM_W-1:0]   pid_sum;
  logic [RND_W-1:0]          rnd_mag;

  // Output register.
  logic [DRIVE_W-1:0] out_drive;
  logic               out_running, out_strong;

  // Shared units.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  gspid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  gspid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Input fields.
  func_t                    in_func;
  logic signed [TEMP_W-1:0] in_temp;
  logic [MS_W-1:0]          in_ms;

  assign in_func = func_t'(s_tuser);
  assign in_temp = $signed(s_tdata[TEMP_W-1:0]);
  assign in_ms   = s_tdata[TEMP_W+MS_W-1:TEMP_W];

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'b0, out_strong, out_running, out_drive};

  // Datapath helpers, one wide add or compare each.
  logic [ERR_W-1:0]          abs_err;
  logic signed [MUL_P_W-1:0] inc_num;
  logic                      inc_sign;
  logic [MUL_P_W-1:0]        inc_half;
  logic signed [DIV_N_W-1:0] d_num;
  logic                      d_sign;
  logic [DIV_N_W-1:0]        d_half;
  logic [ACC_W:0]            inc_q;
  logic [ACC_W:0]            acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ACC_W-1:0]   lim_pos, lim_neg;
  logic [SUM_W-1:0]          sum_u, dq_ext, sum_sub, rnd_sum;
  logic                      sum_neg;
  logic signed [RND_W:0]     out_val, out_hi;

  always_comb begin
    abs_err  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // Integral increment numerator: err * ms * 4096, magnitude plus 500.
    inc_num  = mul_p <<< 12;
    inc_sign = inc_num[MUL_P_W-1];
    inc_half = (inc_sign ? ~inc_num : inc_num) +
               (inc_sign ? MUL_P_W'(MS_PER_S / 2 + 1) : MUL_P_W'(MS_PER_S / 2));

    // Derivative numerator: kd * dT * 1000 * 4096, magnitude plus ms/2.
    d_num  = DIV_N_W'(mul_p) <<< 12;
    d_sign = d_num[DIV_N_W-1];
    d_half = (d_sign ? ~d_num : d_num) + DIV_N_W'(samp_ms >> 1) + DIV_N_W'(d_sign);

    // Integral update with saturation at the 40-bit bounds.
    inc_q   = (ACC_W + 1)'(div_rsp.quot);
    acc_sum = {integral_acc[ACC_W-1], integral_acc} + (inc_neg ? ~inc_q : inc_q) +
              (ACC_W + 1)'(inc_neg);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = $signed(acc_sum[ACC_W-1:0]);
    end

    lim_pos = $signed({{(ACC_W - 2 * LIM_STEPS){1'b0}}, div_rsp.quot[2*LIM_STEPS-1:0]});
    lim_neg = -lim_pos;

    // Subtract the derivative term: sum - D, with D = -q when d_neg.
    sum_u   = pid_sum;
    dq_ext  = SUM_W'(div_rsp.quot);
    sum_sub = sum_u + (d_neg ? dq_ext : ~dq_ext) + SUM_W'(!d_neg);

    // Round to Q8.8, half away from zero.
    sum_neg = pid_sum[SUM_W-1];
    rnd_sum = (sum_neg ? ~sum_u : sum_u) + SUM_W'(2 ** (FRAC_SHIFT - 1)) + SUM_W'(sum_neg);

    // Lower to the upper limit first, then raise to the lower limit.
    out_val = rnd_neg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
    out_hi  = (out_val > DRIVE_HI) ? DRIVE_HI : out_val;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_GAIN: begin
        mul_a = MUL_A_W'(samp_ms);
        mul_b = MUL_B_W'(err);
      end
      S_INC: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(kp);
      end
      S_P: begin
        mul_a = MUL_A_W'(dtemp);
        mul_b = MUL_B_W'(MS_PER_S);
      end
      S_DT: begin
        mul_a = $signed(mul_p[MUL_A_W-1:0]);
        mul_b = MUL_B_W'(kd);
      end
      S_I0: begin
        mul_a = MUL_A_W'(integral_acc[23:0]);
        mul_b = MUL_B_W'(ki);
      end
      S_I1: begin
        mul_a = MUL_A_W'($signed(integral_acc[ACC_W-1:24]));
        mul_b = MUL_B_W'(ki);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Requests to the shared divider.
  always_comb begin
    div_req = '0;
    case (state)
      S_INC: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEP_W'(INC_STEPS);
        div_req.dividend = DIV_N_W'(inc_half) << (DIV_N_W - 2 * INC_STEPS);
        div_req.divisor  = DIV_D_W'(MS_PER_S);
      end
      S_WINC: begin
        div_req.start    = !div_rsp.busy && (ki != '0);
        div_req.steps    = DIV_STEP_W'(LIM_STEPS);
        div_req.dividend = DIV_N_W'(LIM_NUM) << (DIV_N_W - 2 * LIM_STEPS);
        div_req.divisor  = ki;
      end
      S_I0: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEP_W'(DRV_STEPS);
        div_req.dividend = d_dividend;
        div_req.divisor  = samp_ms;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= TARGET_RST;
      switch_band <= BAND_RST;
      kp_gentle   <= KP_G_RST;
      ki_gentle   <= KI_G_RST;
      kd_gentle   <= KD_G_RST;
      kp_strong   <= KP_S_RST;
      ki_strong   <= KI_S_RST;
      kd_strong   <= KD_S_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET:    target_temp <= $signed(cfg_data);
        REG_BAND:      switch_band <= cfg_data[BAND_W-1:0];
        REG_KP_GENTLE: kp_gentle   <= cfg_data;
        REG_KI_GENTLE: ki_gentle   <= cfg_data;
        REG_KD_GENTLE: kd_gentle   <= cfg_data;
        REG_KP_STRONG: kp_strong   <= cfg_data;
        REG_KI_STRONG: ki_strong   <= cfg_data;
        REG_KD_STRONG: kd_strong   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enabled_flag <= 1'b0;
      primed_flag  <= 1'b0;
      strong_mode  <= 1'b0;
      integral_acc <= '0;
      prev_temp    <= '0;
      drive_reg    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // Drop the result once the sink takes it, unless the next one replaces it.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DONE;
            case (in_func)
              FUNC_SAMPLE: begin
                if (!enabled_flag) begin
                  drive_reg <= '0;
                end else if (!primed_flag) begin
                  prev_temp   <= in_temp;
                  primed_flag <= 1'b1;
                end else if (in_ms != '0) begin
                  samp_temp <= in_temp;
                  samp_ms   <= in_ms;
                  state     <= S_SEL;
                end
              end
              FUNC_ENABLE: begin
                enabled_flag <= 1'b1;
                primed_flag  <= 1'b0;
              end
              FUNC_DISABLE: begin
                enabled_flag <= 1'b0;
                drive_reg    <= '0;
              end
              default: begin
                integral_acc <= '0;
                prev_temp    <= '0;
                primed_flag  <= 1'b0;
                drive_reg    <= '0;
              end
            endcase
          end
        end

        S_SEL: begin
          err   <= ERR_W'(target_temp) - ERR_W'(samp_temp);
          dtemp <= ERR_W'(samp_temp) - ERR_W'(prev_temp);
          state <= S_GAIN;
        end

        // Pick the gain set; multiplier starts err * ms.
        S_GAIN: begin
          if (abs_err > ERR_W'(switch_band)) begin
            strong_mode <= 1'b1;
            kp <= kp_strong;
            ki <= ki_strong;
            kd <= kd_strong;
          end else begin
            strong_mode <= 1'b0;
            kp <= kp_gentle;
            ki <= ki_gentle;
            kd <= kd_gentle;
          end
          state <= S_INC;
        end

        // Divider starts the /1000; multiplier starts kp * err.
        S_INC: begin
          inc_neg <= inc_sign;
          state   <= S_P;
        end

        S_P: begin
          pid_sum <= SUM_W'(mul_p) <<< 12;
          state   <= S_DT;
        end

        S_DT: begin
          state <= S_D;
        end

        S_D: begin
          d_neg      <= d_sign;
          d_dividend <= d_half;
          state      <= S_WINC;
        end

        // Integrate; divider starts OUT_MAX * 2^24 / ki when ki is nonzero.
        S_WINC: begin
          if (!div_rsp.busy) begin
            integral_acc <= acc_sat;
            state        <= (ki != '0) ? S_WLIM : S_I0;
          end
        end

        S_WLIM: begin
          if (!div_rsp.busy) begin
            if (integral_acc > lim_pos) begin
              integral_acc <= lim_pos;
            end else if (integral_acc < lim_neg) begin
              integral_acc <= lim_neg;
            end
            state <= S_I0;
          end
        end

        // Divider starts the derivative; multiplier starts ki * low integral.
        S_I0: begin
          state <= S_I1;
        end

        S_I1: begin
          pid_sum <= pid_sum + SUM_W'(mul_p);
          state   <= S_I2;
        end

        S_I2: begin
          pid_sum <= pid_sum + (SUM_W'(mul_p) <<< 24);
          state   <= S_WD;
        end

        S_WD: begin
          if (!div_rsp.busy) begin
            pid_sum <= $signed(sum_sub);
            state   <= S_RND;
          end
        end

        S_RND: begin
          rnd_neg <= sum_neg;
          rnd_mag <= rnd_sum[SUM_W-1:FRAC_SHIFT];
          state   <= S_CLIP;
        end

        S_CLIP: begin
          drive_reg <= (out_hi < DRIVE_LO) ? DRIVE_LO[DRIVE_W-1:0] : out_hi[DRIVE_W-1:0];
          prev_temp <= samp_temp;
          state     <= S_DONE;
        end

        // Hold until the output register is free, then present the result.
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_drive   <= drive_reg;
            out_running <= enabled_flag;
            out_strong  <= strong_mode;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/gspid_checker.sv
// Scoreboard for the gain-scheduled PID controller: tracks state, predicts and checks results.
module gspid_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sample_temp, [31:16] elapsed_ms
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [15:0] drive_level, [16] running, [17] strong_gains
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          pid_updates,
  output int          strong_updates
);
  import gspid_pkg::*;

  localparam longint ACC_TOP = 64'sd549755813887;
  localparam longint ACC_BOT = -ACC_TOP - 1;
  localparam longint DRIVE_TOP = longint'(OUT_MAX) * 256;
  localparam longint DRIVE_BOT = longint'(OUT_MIN) * 256;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      running;
    logic                      strong_set;
  } drive_result_t;

  drive_result_t drive_due [$];

  // Register copies.
  logic signed [TEMP_W-1:0] target_q;
  logic [BAND_W-1:0]        band_q;
  logic [GAIN_W-1:0]        kp_g, ki_g, kd_g, kp_s, ki_s, kd_s;

  // Controller state.
  bit                       enabled_q, primed_q, strong_q;
  logic signed [ACC_W-1:0]  integ_q;
  logic signed [TEMP_W-1:0] prev_q;
  logic signed [DRIVE_W-1:0] drive_q;

  int n_bad, n_res, n_pid, n_strong;

  // Divide with rounding half away from zero; den is positive.
  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  task automatic update_pid(input logic signed [TEMP_W-1:0] temp, input logic [MS_W-1:0] ms);
    longint t, dt, err, kp, ki, kd, acc, lim, sum, lvl;
    t = longint'(temp);
    dt = longint'(ms);
    err = longint'(target_q) - t;
    strong_q = (((err < 0) ? -err : err) > longint'(band_q));
    kp = strong_q ? longint'(kp_s) : longint'(kp_g);
    ki = strong_q ? longint'(ki_s) : longint'(ki_g);
    kd = strong_q ? longint'(kd_s) : longint'(kd_g);

    acc = longint'(integ_q) + div_round(err * dt * 4096, MS_PER_S);
    if (acc > ACC_TOP) acc = ACC_TOP;
    if (acc < ACC_BOT) acc = ACC_BOT;
    // Anti-windup: hold the integral where it alone would saturate the drive.
    if (ki != 0) begin
      lim = (longint'(OUT_MAX) * 16777216) / ki;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
    end
    integ_q = acc[ACC_W-1:0];

    sum = kp * err * 4096 + ki * acc;
    sum = sum - div_round(kd * (t - longint'(prev_q)) * MS_PER_S * 4096, dt);
    lvl = div_round(sum, 65536);
    if (lvl > DRIVE_TOP) lvl = DRIVE_TOP;
    if (lvl < DRIVE_BOT) lvl = DRIVE_BOT;
    drive_q = lvl[DRIVE_W-1:0];
    prev_q = temp;
    n_pid++;
    if (strong_q) n_strong++;
  endtask

  task automatic step_controller(input func_t f, input logic signed [TEMP_W-1:0] temp,
                                 input logic [MS_W-1:0] ms);
    drive_result_t r;
    case (f)
      FUNC_SAMPLE: begin
        if (!enabled_q) begin
          drive_q = '0;
        end else if (!primed_q) begin
          prev_q = temp;
          primed_q = 1'b1;
        end else if (ms != '0) begin
          update_pid(temp, ms);
        end
      end
      FUNC_ENABLE: begin
        enabled_q = 1'b1;
        primed_q = 1'b0;
      end
      FUNC_DISABLE: begin
        enabled_q = 1'b0;
        drive_q = '0;
      end
      default: begin
        integ_q = '0;
        prev_q = '0;
        primed_q = 1'b0;
        drive_q = '0;
      end
    endcase
    r.drive = drive_q;
    r.running = enabled_q;
    r.strong_set = strong_q;
    drive_due.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    drive_result_t got, want;
    if (rst) begin
      target_q = TARGET_RST;
      band_q = BAND_RST;
      kp_g = KP_G_RST;
      ki_g = KI_G_RST;
      kd_g = KD_G_RST;
      kp_s = KP_S_RST;
      ki_s = KI_S_RST;
      kd_s = KD_S_RST;
      enabled_q = 1'b0;
      primed_q = 1'b0;
      strong_q = 1'b0;
      integ_q = '0;
      prev_q = '0;
      drive_q = '0;
      drive_due.delete();
    end else begin
      // Retire before predicting: a result never belongs to the item taken at the same edge.
      if (m_tvalid && m_tready) begin
        got.drive = m_tdata[15:0];
        got.running = m_tdata[16];
        got.strong_set = m_tdata[17];
        n_res++;
        if (drive_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result with no item waiting: drive %0d running %0b strong %0b",
                     $realtime, got.drive, got.running, got.strong_set);
        end else begin
          want = drive_due.pop_front();
          if (got.drive !== want.drive || got.running !== want.running ||
              got.strong_set !== want.strong_set) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch: want drive %0d running %0b strong %0b, got %0d %0b %0b",
                       $realtime, want.drive, want.running, want.strong_set,
                       got.drive, got.running, got.strong_set);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET:    target_q = cfg_data;
          REG_BAND:      band_q = cfg_data[BAND_W-1:0];
          REG_KP_GENTLE: kp_g = cfg_data;
          REG_KI_GENTLE: ki_g = cfg_data;
          REG_KD_GENTLE: kd_g = cfg_data;
          REG_KP_STRONG: kp_s = cfg_data;
          REG_KI_STRONG: ki_s = cfg_data;
          REG_KD_STRONG: kd_s = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        step_controller(func_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]);
    end
    mismatches <= n_bad;
    outstanding <= drive_due.size();
    results_checked <= n_res;
    pid_updates <= n_pid;
    strong_updates <= n_strong;
  end

endmodule

FILE: test/tb_gain_scheduled_pid_controller.sv
// Testbench top for the gain-scheduled PID controller: stimulus, pacing and verdict.
module tb_gain_scheduled_pid_controller;
  import gspid_pkg::*;

  localparam int NUM_REGS = int'(REG_KD_STRONG) + 1;
  localparam int NUM_PLANS = 6;

  // Handshake pacing modes, cycled through the phases.
  typedef enum int {PACE_FREE, PACE_SLOW_SEND, PACE_SLOW_TAKE, PACE_BOTH} pace_t;

  // Register settings walked after the default phase.
  typedef enum int {
    PLAN_MAX,
    PLAN_ZERO,
    PLAN_NO_INTEGRAL,
    PLAN_RAW,
    PLAN_TYPICAL,
    PLAN_DEFAULT
  } cfg_plan_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] sample_temp, [31:16] elapsed_ms
  logic [1:0]  s_tuser = '0;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] drive_level, [16] running, [17] strong_gains
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches, outstanding, results_checked, pid_updates, strong_updates;
  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int settings_used = 0;
  int target_now = 3200;
  int band_now = 160;
  logic [15:0] reg_plan [NUM_REGS];

  gain_scheduled_pid_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  gspid_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .pid_updates    (pid_updates),
    .strong_updates (strong_updates)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: drop tready at random according to the current stall rate.
  always @(posedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  // Hard stop well beyond the slowest legal run (full samples, long stalls).
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic set_pacing(input pace_t mode);
    case (mode)
      PACE_FREE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      PACE_SLOW_SEND: begin
        gap_pct = 79;
        stall_pct = 0;
      end
      PACE_SLOW_TAKE: begin
        gap_pct = 0;
        stall_pct = 79;
      end
      PACE_BOTH: begin
        gap_pct = 32;
        stall_pct = 32;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // Offer one item, idling first at the sender's gap rate; return once it is taken.
  // Leave tvalid high so back-to-back items need no extra assignment.
  task automatic send_item(input func_t f, input logic [15:0] temp, input logic [15:0] ms);
    while (int'($urandom_range(99)) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {ms, temp};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Hold until every predicted result has come back. The count from the
  // checker is registered, so always step once before looking at it.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write every register from reg_plan, back to back, then drop cfg_valid once.
  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= reg_plan[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    target_now = int'($signed(reg_plan[REG_TARGET]));
    band_now = int'(reg_plan[REG_BAND][BAND_W-1:0]);
    settings_used++;
  endtask

  task automatic plan_regs(input cfg_plan_t plan);
    case (plan)
      PLAN_MAX: begin
        // Bit 15 of the band write must be dropped by the block.
        foreach (reg_plan[i]) reg_plan[i] = 16'hffff;
        reg_plan[REG_TARGET] = 16'h7fff;
      end
      PLAN_ZERO: begin
        foreach (reg_plan[i]) reg_plan[i] = 16'h0000;
        reg_plan[REG_TARGET] = 16'h8000;
      end
      PLAN_NO_INTEGRAL: begin
        // ki zero on both sets: no anti-windup clamp, only 40-bit saturation.
        reg_plan[REG_TARGET] = 16'd1600;
        reg_plan[REG_BAND] = 16'd80;
        reg_plan[REG_KP_GENTLE] = 16'd800;
        reg_plan[REG_KI_GENTLE] = 16'd0;
        reg_plan[REG_KD_GENTLE] = 16'd100;
        reg_plan[REG_KP_STRONG] = 16'd3000;
        reg_plan[REG_KI_STRONG] = 16'd0;
        reg_plan[REG_KD_STRONG] = 16'd400;
      end
      PLAN_RAW: begin
        foreach (reg_plan[i]) reg_plan[i] = 16'($urandom);
      end
      PLAN_TYPICAL: begin
        foreach (reg_plan[i]) reg_plan[i] = 16'($urandom_range(2048));
        reg_plan[REG_TARGET] = 16'(int'($urandom_range(4800)) - 800);
        reg_plan[REG_BAND] = 16'($urandom_range(400));
      end
      default: begin
        reg_plan[REG_TARGET] = TARGET_RST;
        reg_plan[REG_BAND] = 16'(BAND_RST);
        reg_plan[REG_KP_GENTLE] = KP_G_RST;
        reg_plan[REG_KI_GENTLE] = KI_G_RST;
        reg_plan[REG_KD_GENTLE] = KD_G_RST;
        reg_plan[REG_KP_STRONG] = KP_S_RST;
        reg_plan[REG_KI_STRONG] = KI_S_RST;
        reg_plan[REG_KD_STRONG] = KD_S_RST;
      end
    endcase
  endtask

  function automatic logic [15:0] clamp_temp(input int t);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  function automatic logic [15:0] temp_near(input int span);
    return clamp_temp(target_now + int'($urandom_range(2 * span)) - span);
  endfunction

  // Mostly a few hertz; sometimes tiny (large derivative), full range or zero.
  function automatic logic [15:0] pick_ms();
    int r;
    r = int'($urandom_range(99));
    if (r < 3) return 16'd0;
    if (r < 13) return 16'($urandom_range(5, 1));
    if (r < 20) return 16'($urandom);
    return 16'($urandom_range(1000, 50));
  endfunction

  // A well-formed control run: optional enable or reset, then samples around the setpoint.
  task automatic sample_run();
    int len, span, sel;
    logic [15:0] temp;
    sel = int'($urandom_range(5));
    if (sel < 2) send_item(FUNC_ENABLE, 16'($urandom), 16'($urandom));
    else if (sel == 2) send_item(FUNC_RESET, 16'($urandom), 16'($urandom));
    case ($urandom_range(2))
      0: span = band_now + 40;
      1: span = 1500;
      default: span = 40000;
    endcase
    len = int'($urandom_range(20, 4));
    repeat (len) begin
      // Now and then land exactly on the band edge or one step past it.
      if ($urandom_range(9) == 0)
        temp = clamp_temp(target_now + ($urandom_range(1) ? 1 : -1) *
                          (band_now + int'($urandom_range(1))));
      else
        temp = temp_near(span);
      send_item(FUNC_SAMPLE, temp, pick_ms());
    end
  endtask

  // Drive the integral toward its limits: one extreme temperature, long intervals.
  task automatic windup_burst(input int len);
    logic [15:0] temp;
    temp = $urandom_range(1) ? 16'h7fff : 16'h8000;
    send_item(FUNC_ENABLE, 16'($urandom), 16'($urandom));
    repeat (len) send_item(FUNC_SAMPLE, temp, 16'($urandom_range(65535, 60000)));
  endtask

  task automatic random_phase(input int count);
    int first, r;
    first = items_sent;
    while (items_sent - first < count) begin
      r = int'($urandom_range(99));
      if (r < 60) begin
        sample_run();
      end else if (r < 90) begin
        // Noise: any command with any payload.
        send_item(func_t'($urandom_range(3)), 16'($urandom), 16'($urandom));
      end else if (r < 96) begin
        windup_burst(12);
      end else begin
        // Hold off the sender until the block has emptied.
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_pacing(PACE_FREE);

    // Directed pass on reset defaults (setpoint 3200, band 160).
    send_item(FUNC_SAMPLE, 16'h8000, 16'hffff);   // sample while disabled
    send_item(FUNC_DISABLE, 16'h0000, 16'h0000);
    send_item(FUNC_ENABLE, 16'h0000, 16'h0000);
    send_item(FUNC_SAMPLE, 16'd3000, 16'd0);       // first sample only primes
    send_item(FUNC_SAMPLE, 16'd3000, 16'd0);       // zero elapsed time: no change
    send_item(FUNC_SAMPLE, 16'd3100, 16'd250);     // gentle gains
    send_item(FUNC_SAMPLE, 16'd3040, 16'd1000);    // error equal to band: still gentle
    send_item(FUNC_SAMPLE, 16'd3039, 16'd1000);    // one step past band: strong
    send_item(FUNC_SAMPLE, 16'h7fff, 16'hffff);    // far above setpoint: drive at low limit
    send_item(FUNC_SAMPLE, 16'h8000, 16'd1);       // huge derivative: drive at high limit
    send_item(FUNC_SAMPLE, 16'h8000, 16'hffff);
    send_item(FUNC_SAMPLE, 16'd3200, 16'd100);     // zero error
    send_item(FUNC_RESET, 16'hffff, 16'hffff);
    send_item(FUNC_SAMPLE, 16'd2500, 16'd0);       // primes again after reset
    send_item(FUNC_SAMPLE, 16'd2600, 16'd300);
    send_item(FUNC_ENABLE, 16'h0000, 16'h0000);    // enable while running re-primes
    send_item(FUNC_SAMPLE, 16'd2700, 16'd300);
    send_item(FUNC_SAMPLE, 16'd2800, 16'hffff);
    send_item(FUNC_DISABLE, 16'h0000, 16'h0000);
    send_item(FUNC_SAMPLE, 16'd3000, 16'd500);     // disabled: drive stays zero
    send_item(FUNC_ENABLE, 16'h0000, 16'h0000);
    send_item(FUNC_RESET, 16'h0000, 16'h0000);     // reset keeps the enable
    send_item(FUNC_SAMPLE, 16'h5555, 16'haaaa);
    send_item(FUNC_SAMPLE, 16'haaaa, 16'h5555);
    random_phase(60);
    s_tvalid <= 1'b0;
    wait_drained();

    // Walk the register settings; change them only with nothing in flight.
    for (int p = 0; p < NUM_PLANS; p++) begin
      plan_regs(cfg_plan_t'(p));
      program_regs();
      set_pacing(pace_t'((p + 1) % 4));
      if (cfg_plan_t'(p) == PLAN_ZERO || cfg_plan_t'(p) == PLAN_NO_INTEGRAL)
        windup_burst(32);
      random_phase(50);
      s_tvalid <= 1'b0;
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (120) @(posedge clk);
    $display("Sent %0d items and checked %0d results over %0d register settings and 4 pacings;",
             items_sent, results_checked, settings_used + 1);
    $display("%0d samples ran the full control law, %0d of them on the strong gain set.",
             pid_updates, strong_updates);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
